// File: hdl/bpt_pkg.sv
package bpt_pkg;

  localparam int PHASE_COUNT = 16;
  localparam int IDX_W = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
  localparam logic [31:0] INJECT_BASE = 32'hFFFF_FC18; // -1000

  typedef enum logic [3:0] {
    OP_BEGIN      = 4'd0,
    OP_SUCCEED    = 4'd1,
    OP_FAIL       = 4'd2,
    OP_ROLLBACK   = 4'd3,
    OP_ARM        = 4'd4,
    OP_DISARM     = 4'd5,
    OP_DISARM_ALL = 4'd6,
    OP_CONSUME    = 4'd7,
    OP_READ_SLOT  = 4'd8,
    OP_READ_GLOB  = 4'd9,
    OP_RESET_EXEC = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    RC_OK     = 2'd0,
    RC_BADARG = 2'd1,
    RC_ORDER  = 2'd2,
    RC_STATE  = 2'd3
  } rc_t;

  typedef enum logic [2:0] {
    ST_PENDING = 3'd0,
    ST_RUNNING = 3'd1,
    ST_DONE    = 3'd2,
    ST_FAILED  = 3'd3,
    ST_ROLLED  = 3'd4
  } slot_st_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_EXEC,
    FS_RB_ISSUE,
    FS_RB_MOD,
    FS_RB_FIN
  } fsm_t;

  typedef struct packed {
    slot_st_t    status;
    logic [31:0] enter;
    logic [31:0] leave;
    logic [31:0] attempts;
    logic [31:0] fails;
    logic [31:0] rollbacks;
    logic [31:0] error;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  function automatic logic [31:0] default_inject(input logic [IDX_W-1:0] p);
    return INJECT_BASE - 32'(p);
  endfunction

endpackage

// File: hdl/bpt_in_if.sv
interface bpt_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [4:0]  phase;
  logic signed [31:0] fault_code;

  modport source (output valid, opcode, phase, fault_code, input ready);
  modport sink (input valid, opcode, phase, fault_code, output ready);
endinterface

// File: hdl/bpt_out_if.sv
interface bpt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_code;
  logic        hit_flag;
  logic [4:0]  changed_count;
  logic [2:0]  phase_status;
  logic [31:0] enter_stamp;
  logic [31:0] leave_stamp;
  logic [31:0] attempt_total;
  logic [31:0] fail_total;
  logic [31:0] rollback_total;
  logic signed [31:0] error_value;
  logic [4:0]  active_index;
  logic        boot_done;

  modport source (output valid, result_code, hit_flag, changed_count, phase_status,
                  enter_stamp, leave_stamp, attempt_total, fail_total, rollback_total,
                  error_value, active_index, boot_done, input ready);
  modport sink (input valid, result_code, hit_flag, changed_count, phase_status,
                enter_stamp, leave_stamp, attempt_total, fail_total, rollback_total,
                error_value, active_index, boot_done, output ready);
endinterface

// File: hdl/boot_phase_tracker_unit.sv
// Sequence: a beat is taken in idle and run in exec, which loads the output register; a
//   rollback walks the active slot if at or past its phase, then that phase to the last.
// Throughput: one beat per item; a new beat is taken once the previous result is loaded
//   into the output register. Each rollback walk step reads, and may rewrite, one slot.
// Reset (rst_n low, synchronous): all slots read as pending/zero, injected codes read as
//   their defaults, nothing armed, no active phase. No memory clearing pass is needed.
module boot_phase_tracker_unit (
  input logic      clk,
  input logic      rst_n,
  bpt_in_if.sink   in_beat,
  bpt_out_if.source out_beat
);
  import bpt_pkg::*;

  localparam logic [5:0] PC6 = 6'(PHASE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PHASE_COUNT - 1);

  // control state
  fsm_t state_r, state_nxt;
  op_t  op_r;
  logic [4:0]  phase_r;
  logic [31:0] err_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic rb_act_r, rb_act_nxt;
  logic [4:0] chg_r, chg_nxt;

  // architectural state held in flops
  logic [31:0] counter_r, counter_nxt;
  logic active_r, active_nxt;
  logic [IDX_W-1:0] act_slot_r, act_slot_nxt;
  logic complete_r, complete_nxt;
  logic [31:0] gerr_r, gerr_nxt;
  logic [PHASE_COUNT-1:0] armed_r, armed_nxt;
  logic [PHASE_COUNT-1:0] slot_vld_r, slot_vld_nxt; // entry not valid reads as reset slot
  logic [PHASE_COUNT-1:0] inj_vld_r, inj_vld_nxt;   // entry not valid reads default code
  logic [PHASE_COUNT-1:0] done_r, done_nxt;         // mirror of status == done

  // output register
  logic out_valid_r;
  logic out_load;
  logic [1:0]  o_rc;
  logic        o_hit;
  logic [2:0]  o_status;
  logic [31:0] o_enter, o_leave, o_att, o_fail, o_rb, o_err;
  logic [1:0]  o_rc_r;
  logic        o_hit_r;
  logic [4:0]  o_chg_r;
  logic [2:0]  o_status_r;
  logic [31:0] o_enter_r, o_leave_r, o_att_r, o_fail_r, o_rb_r, o_err_r;
  logic [4:0]  o_act_r;
  logic        o_done_r;

  // memories
  logic slot_we;
  logic [IDX_W-1:0] slot_waddr, slot_raddr;
  slot_t slot_wdata, slot_rdata_raw, cur;
  logic [SLOT_W-1:0] slot_rbits;
  logic inj_we;
  logic [31:0] inj_wdata, inj_rdata, inj_cur;

  logic [IDX_W-1:0] p_idx;
  logic p_ok, out_free;
  logic [PHASE_COUNT-1:0] lo_mask, done_set;

  bpt_ram #(.WIDTH(SLOT_W), .DEPTH(PHASE_COUNT)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rbits)
  );

  bpt_ram #(.WIDTH(32), .DEPTH(PHASE_COUNT)) u_inject_ram (
    .clk(clk), .we(inj_we), .waddr(p_idx), .wdata(inj_wdata),
    .raddr(slot_raddr), .rdata(inj_rdata)
  );

  assign slot_rdata_raw = slot_t'(slot_rbits);
  assign p_idx    = phase_r[IDX_W-1:0];
  assign p_ok     = {1'b0, phase_r} < PC6;
  assign out_free = !out_valid_r || out_beat.ready;
  assign lo_mask  = (PHASE_COUNT'(1) << p_idx) - PHASE_COUNT'(1);
  assign in_beat.ready = (state_r == FS_IDLE);

  // read address: the phase being taken in, held through exec; the walk index otherwise
  always_comb begin
    case (state_r)
      FS_IDLE:     slot_raddr = in_beat.phase[IDX_W-1:0];
      FS_EXEC:     slot_raddr = p_idx;
      default:     slot_raddr = idx_r;
    endcase
  end

  // slot contents as seen by exec (p_idx) or the walk (idx_r)
  always_comb begin
    cur = slot_rdata_raw;
    if (state_r == FS_EXEC) begin
      if (!slot_vld_r[p_idx]) cur = '0;
    end else begin
      if (!slot_vld_r[idx_r]) cur = '0;
    end
    inj_cur = inj_vld_r[p_idx] ? inj_rdata : default_inject(p_idx);
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    rb_act_nxt   = rb_act_r;
    chg_nxt      = chg_r;
    counter_nxt  = counter_r;
    active_nxt   = active_r;
    act_slot_nxt = act_slot_r;
    complete_nxt = complete_r;
    gerr_nxt     = gerr_r;
    armed_nxt    = armed_r;
    slot_vld_nxt = slot_vld_r;
    inj_vld_nxt  = inj_vld_r;
    done_set     = done_r;
    slot_we      = 1'b0;
    slot_waddr   = p_idx;
    slot_wdata   = cur;
    inj_we       = 1'b0;
    inj_wdata    = err_r;
    out_load     = 1'b0;
    o_rc         = RC_OK;
    o_hit        = 1'b0;
    o_status     = '0;
    o_enter      = '0;
    o_leave      = '0;
    o_att        = '0;
    o_fail       = '0;
    o_rb         = '0;
    o_err        = '0;

    case (state_r)
      FS_IDLE: begin
        if (in_beat.valid) state_nxt = FS_EXEC;
      end

      FS_EXEC: begin
        if (op_r == OP_ROLLBACK && p_ok) begin
          chg_nxt      = '0;
          // boot is no longer complete once a rollback starts, whether or not a slot is rolled back
          complete_nxt = 1'b0;
          if (active_r && act_slot_r >= p_idx) begin
            idx_nxt    = act_slot_r;
            rb_act_nxt = 1'b1;
          end else begin
            idx_nxt    = p_idx;
            rb_act_nxt = 1'b0;
          end
          state_nxt = FS_RB_ISSUE;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = FS_IDLE;
          case (op_r)
            OP_BEGIN: begin
              if (!p_ok) o_rc = RC_BADARG;
              else if (active_r) o_rc = RC_STATE;
              else if (!(&(done_r | ~lo_mask))) o_rc = RC_ORDER;
              else if (cur.status == ST_RUNNING) o_rc = RC_STATE;
              else begin
                counter_nxt         = counter_r + 32'd1;
                slot_wdata.status   = ST_RUNNING;
                slot_wdata.enter    = counter_nxt;
                slot_wdata.attempts = cur.attempts + 32'd1;
                slot_wdata.error    = '0;
                slot_we             = 1'b1;
                active_nxt          = 1'b1;
                act_slot_nxt        = p_idx;
                complete_nxt        = 1'b0;
              end
            end
            OP_SUCCEED, OP_FAIL: begin
              if (!p_ok) o_rc = RC_BADARG;
              else if (!active_r || act_slot_r != p_idx || cur.status != ST_RUNNING) begin
                o_rc = RC_STATE;
              end else begin
                counter_nxt      = counter_r + 32'd1;
                slot_wdata.leave = counter_nxt;
                slot_we          = 1'b1;
                active_nxt       = 1'b0;
                act_slot_nxt     = '0;
                if (op_r == OP_SUCCEED) begin
                  slot_wdata.status = ST_DONE;
                  slot_wdata.error  = '0;
                  gerr_nxt          = '0;
                  complete_nxt      = &(done_r | (PHASE_COUNT'(1) << p_idx));
                end else begin
                  slot_wdata.status = ST_FAILED;
                  slot_wdata.fails  = cur.fails + 32'd1;
                  slot_wdata.error  = err_r;
                  gerr_nxt          = err_r;
                  complete_nxt      = 1'b0;
                end
              end
            end
            OP_ROLLBACK: o_rc = RC_BADARG;
            OP_ARM: begin
              if (!p_ok) o_rc = RC_BADARG;
              else begin
                armed_nxt[p_idx]   = 1'b1;
                inj_we             = 1'b1;
                inj_wdata          = (err_r != '0) ? err_r : default_inject(p_idx);
                inj_vld_nxt[p_idx] = 1'b1;
              end
            end
            OP_DISARM: begin
              if (!p_ok) o_rc = RC_BADARG;
              else armed_nxt[p_idx] = 1'b0;
            end
            OP_DISARM_ALL: armed_nxt = '0;
            OP_CONSUME: begin
              if (!p_ok) o_rc = RC_BADARG;
              else if (armed_r[p_idx]) begin
                o_hit            = 1'b1;
                o_err            = inj_cur;
                armed_nxt[p_idx] = 1'b0;
              end
            end
            OP_READ_SLOT: begin
              if (!p_ok) o_rc = RC_BADARG;
              else begin
                o_status = cur.status;
                o_enter  = cur.enter;
                o_leave  = cur.leave;
                o_att    = cur.attempts;
                o_fail   = cur.fails;
                o_rb     = cur.rollbacks;
                o_err    = cur.error;
              end
            end
            OP_READ_GLOB: begin
              o_hit = &done_r;
              o_err = gerr_r;
            end
            OP_RESET_EXEC: begin
              slot_vld_nxt = '0;
              done_set     = '0;
              counter_nxt  = '0;
              active_nxt   = 1'b0;
              act_slot_nxt = '0;
              complete_nxt = 1'b0;
              gerr_nxt     = '0;
            end
            default: o_rc = RC_BADARG;
          endcase
          // only a walked rollback reports a count
          chg_nxt = '0;
        end
      end

      FS_RB_ISSUE: state_nxt = FS_RB_MOD;

      FS_RB_MOD: begin
        slot_waddr = idx_r;
        if (rb_act_r || cur.status == ST_DONE || cur.status == ST_FAILED) begin
          counter_nxt          = counter_r + 32'd1;
          slot_wdata.status    = ST_ROLLED;
          slot_wdata.leave     = counter_nxt;
          slot_wdata.rollbacks = cur.rollbacks + 32'd1;
          slot_wdata.error     = '0;
          slot_we              = 1'b1;
          chg_nxt              = chg_r + 5'd1;
        end
        if (rb_act_r) begin
          active_nxt   = 1'b0;
          act_slot_nxt = '0;
          rb_act_nxt   = 1'b0;
          idx_nxt      = p_idx;
          state_nxt    = FS_RB_ISSUE;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = FS_RB_FIN;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = FS_RB_ISSUE;
        end
      end

      FS_RB_FIN: begin
        complete_nxt = 1'b0;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = FS_IDLE;
        end
      end

      default: state_nxt = FS_IDLE;
    endcase

    if (slot_we) begin
      slot_vld_nxt[slot_waddr] = 1'b1;
      done_set[slot_waddr]     = (slot_wdata.status == ST_DONE);
    end
    done_nxt = done_set;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_IDLE;
      rb_act_r    <= 1'b0;
      counter_r   <= '0;
      active_r    <= 1'b0;
      act_slot_r  <= '0;
      complete_r  <= 1'b0;
      gerr_r      <= '0;
      armed_r     <= '0;
      slot_vld_r  <= '0;
      inj_vld_r   <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rb_act_r    <= rb_act_nxt;
      counter_r   <= counter_nxt;
      active_r    <= active_nxt;
      act_slot_r  <= act_slot_nxt;
      complete_r  <= complete_nxt;
      gerr_r      <= gerr_nxt;
      armed_r     <= armed_nxt;
      slot_vld_r  <= slot_vld_nxt;
      inj_vld_r   <= inj_vld_nxt;
      done_r      <= done_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_beat.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    chg_r <= chg_nxt;
    if (state_r == FS_IDLE && in_beat.valid) begin
      op_r    <= op_t'(in_beat.opcode);
      phase_r <= in_beat.phase;
      err_r   <= in_beat.fault_code;
    end
    if (out_load) begin
      o_rc_r     <= o_rc;
      o_hit_r    <= o_hit;
      o_chg_r    <= chg_nxt;
      o_status_r <= o_status;
      o_enter_r  <= o_enter;
      o_leave_r  <= o_leave;
      o_att_r    <= o_att;
      o_fail_r   <= o_fail;
      o_rb_r     <= o_rb;
      o_err_r    <= o_err;
      o_act_r    <= active_nxt ? 5'(act_slot_nxt) : 5'(PHASE_COUNT);
      o_done_r   <= complete_nxt;
    end
  end

  assign out_beat.valid          = out_valid_r;
  assign out_beat.result_code    = o_rc_r;
  assign out_beat.hit_flag       = o_hit_r;
  assign out_beat.changed_count  = o_chg_r;
  assign out_beat.phase_status   = o_status_r;
  assign out_beat.enter_stamp    = o_enter_r;
  assign out_beat.leave_stamp    = o_leave_r;
  assign out_beat.attempt_total  = o_att_r;
  assign out_beat.fail_total     = o_fail_r;
  assign out_beat.rollback_total = o_rb_r;
  assign out_beat.error_value    = o_err_r;
  assign out_beat.active_index   = o_act_r;
  assign out_beat.boot_done      = o_done_r;

`ifndef NO_ASSERTIONS
  // a running phase is never flagged done
  a_active_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> !done_r[act_slot_r]) else $error("active phase marked done");
  // boot complete only with every phase done
  a_complete_all: assert property (@(posedge clk) disable iff (!rst_n)
    complete_r |-> &done_r) else $error("complete without all phases done");
  // slot memory is written only from exec or the rollback walk
  a_slot_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    slot_we |-> (state_r == FS_EXEC || state_r == FS_RB_MOD))
    else $error("slot write outside exec/walk");
  // a result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free) else $error("result overwrote pending beat");
`endif
endmodule

// File: hdl/bpt_ram.sv
module bpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
